FILE: src/itacc_pkg.sv
// itacc_pkg: shared types, constants and axis tables for the inertia tensor accumulator.
// Used by inertia_tensor_accumulator and itacc_checker; depends on nothing else.
package itacc_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int SUM_BITS_DEF   = 64;
  localparam int NUM_SUMS       = 6;

  // last step index of each sequencer phase
  localparam logic [4:0] CROSS_OPS_LAST = 5'd5;
  localparam logic [4:0] POLY_LAST      = 5'd5;
  localparam logic [2:0] TERM_LAST      = 3'd4;
  localparam logic [4:0] DET_OPS_LAST   = 5'd2;
  localparam logic [4:0] BIG_OPS_LAST   = 5'd11;
  localparam logic [4:0] SUM_OPS_LAST   = 5'd8;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CROSS,
    ST_POLY,
    ST_DET,
    ST_BIG,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DST_CROSS,
    DST_DET,
    DST_POLY,
    DST_BIG
  } dst_t;

  // tag that travels with a product through the multiplier register
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       shift;
    dst_t       dst;
    logic [2:0] idx;
  } tag_t;

  // cross product component k = a(k) x b(k) terms
  function automatic logic [1:0] cross_axis_a(input logic [1:0] k);
    case (k)
      2'd0:    cross_axis_a = AX_Y;
      2'd1:    cross_axis_a = AX_Z;
      default: cross_axis_a = AX_X;
    endcase
  endfunction

  function automatic logic [1:0] cross_axis_b(input logic [1:0] k);
    case (k)
      2'd0:    cross_axis_b = AX_Z;
      2'd1:    cross_axis_b = AX_X;
      default: cross_axis_b = AX_Y;
    endcase
  endfunction

  // polynomial i pairs axes (a, b): xx, yy, zz, xy, zy, zx
  function automatic logic [1:0] poly_axis_a(input logic [2:0] i);
    case (i)
      3'd0:    poly_axis_a = AX_X;
      3'd1:    poly_axis_a = AX_Y;
      3'd2:    poly_axis_a = AX_Z;
      3'd3:    poly_axis_a = AX_X;
      3'd4:    poly_axis_a = AX_Z;
      3'd5:    poly_axis_a = AX_Z;
      default: poly_axis_a = AX_X;
    endcase
  endfunction

  function automatic logic [1:0] poly_axis_b(input logic [2:0] i);
    case (i)
      3'd0:    poly_axis_b = AX_X;
      3'd1:    poly_axis_b = AX_Y;
      3'd2:    poly_axis_b = AX_Z;
      3'd3:    poly_axis_b = AX_Y;
      3'd4:    poly_axis_b = AX_Y;
      3'd5:    poly_axis_b = AX_X;
      default: poly_axis_b = AX_X;
    endcase
  endfunction

endpackage

FILE: src/inertia_tensor_accumulator.sv
// inertia_tensor_accumulator: fan-triangulates a facet vertex stream into tetrahedra and
// accumulates six saturating inertia tensor sums (scaled by 120) on one shared multiplier.
// Depends on itacc_pkg.
//
//  channel  | dir | signals                              | contents
//  ---------+-----+--------------------------------------+-------------------------------
//  s_axis   | in  | tvalid tready tdata tuser tlast      | vertex, facet start, object end
//  m_axis   | out | tvalid tready tdata                  | six tensor sums
//  cfg      | in  | cfg_wr_en cfg_wr_data                | reference_z (apex z)
//
// A vertex that opens a facet or gives its second point goes through transfer and finish only.
// A vertex that closes a fan triangle sends every product (cross terms, determinant,
// 30 polynomial terms, 12 half-width det x polynomial products) one per cycle, waiting
// for write-backs, through the single 37x18 signed multiplier (at COORD_BITS = 10), then
// nine saturating adds. An object_last vertex waits in the finish cycle while the previous
// result is still untaken; the result register lets the next vertex in while one sits unread.
// rst is synchronous: sums, facet state, reference_z and the output valid are cleared.
module inertia_tensor_accumulator #(
  parameter int COORD_BITS = itacc_pkg::COORD_BITS_DEF,
  parameter int SUM_BITS   = itacc_pkg::SUM_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // vx_coord, vy_coord, vz_coord from bit 0 up, zero padded to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]            s_axis_tdata,
  // facet_first
  input  logic                                         s_axis_tuser,
  // object_last
  input  logic                                         s_axis_tlast,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // moment_xx, moment_yy, moment_zz, product_xy, product_yz, product_xz from bit 0 up
  output logic [((6*SUM_BITS+7)/8)*8-1:0]              m_axis_tdata,
  input  logic                                         cfg_wr_en,
  input  logic [COORD_BITS:0]                          cfg_wr_data
);
  import itacc_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int ZW   = CW + 1;          // apex z
  localparam int DW   = CW + 2;          // vertex minus apex
  localparam int SW   = CW + 3;          // sum of three relative coordinates
  localparam int BW   = CW + 8;          // multiplier B port
  localparam int XW   = 2 * CW + 4;      // cross product component
  localparam int DETW = 3 * CW + 7;      // determinant
  localparam int PW   = 2 * CW + 8;      // tetrahedron polynomial
  localparam int LOW  = CW + 7;          // low split of polynomial, unsigned
  localparam int AW   = DETW;            // multiplier A port
  localparam int MW   = AW + BW;
  localparam int ACW  = MW + LOW;        // accumulator
  localparam int EW   = (ACW > SUM_BITS) ? ACW : SUM_BITS;
  localparam int ODW  = ((6 * SUM_BITS + 7) / 8) * 8;

  localparam logic signed [SUM_BITS-1:0] SMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SMIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // sequencer
  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [2:0] sub, sub_next;
  logic       accept;
  logic       emit;
  logic       stall;

  // vertex state
  logic signed [CW-1:0] in_c [3];
  logic signed [CW-1:0] base_c [3];
  logic signed [CW-1:0] prev_c [3];
  logic signed [CW-1:0] cur_c [3];
  logic [1:0]           facet_cnt;
  logic                 last_q;
  logic signed [ZW-1:0] reference_z;

  // operands prepared per tetrahedron
  logic signed [DW-1:0] rel_u [3];
  logic signed [DW-1:0] rel_v [3];
  logic signed [DW-1:0] rel_w [3];
  logic signed [SW-1:0] s_c [3];
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] v_r [3];
  logic signed [DW-1:0] w_r [3];
  logic signed [SW-1:0] s_r [3];
  logic signed [BW-1:0] e_qz, e_myz, e_mxz;

  // intermediate results
  logic signed [XW-1:0]       cross_r [3];
  logic signed [DETW-1:0]     det_r;
  logic signed [PW-1:0]       poly_r [NUM_SUMS];
  logic signed [SUM_BITS-1:0] big_r [NUM_SUMS];
  logic signed [SUM_BITS-1:0] pair_r [3];
  logic signed [SUM_BITS-1:0] tensor [NUM_SUMS];
  logic signed [SUM_BITS-1:0] out_r [NUM_SUMS];
  logic                       m_valid;

  // shared multiplier and accumulator
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  tag_t                   tag, tag_q;
  logic signed [MW-1:0]   prod_q;
  logic signed [ACW-1:0]  acc, addend, acc_sum;
  logic signed [EW-1:0]   sum_e;
  logic signed [SUM_BITS-1:0] big_sat;

  // saturating adder for the final sums
  logic signed [SUM_BITS-1:0] sa, sb, sat_sum;
  logic signed [SUM_BITS:0]   s_wide;

  logic [1:0] ax_a, ax_b;
  logic [2:0] pi;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit          = (state == ST_DONE) && last_q && (!m_valid || m_axis_tready);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = ODW'({out_r[5], out_r[4], out_r[3], out_r[2], out_r[1], out_r[0]});

  assign in_c[0] = $signed(s_axis_tdata[CW-1:0]);
  assign in_c[1] = $signed(s_axis_tdata[2*CW-1:CW]);
  assign in_c[2] = $signed(s_axis_tdata[3*CW-1:2*CW]);

  // relative vectors to the apex (0, 0, reference_z) and their axis sums
  always_comb begin
    rel_u[0] = DW'(base_c[0]);
    rel_u[1] = DW'(base_c[1]);
    rel_u[2] = DW'(base_c[2]) - DW'(reference_z);
    rel_v[0] = DW'(prev_c[0]);
    rel_v[1] = DW'(prev_c[1]);
    rel_v[2] = DW'(prev_c[2]) - DW'(reference_z);
    rel_w[0] = DW'(cur_c[0]);
    rel_w[1] = DW'(cur_c[1]);
    rel_w[2] = DW'(cur_c[2]) - DW'(reference_z);
    for (int k = 0; k < 3; k++) begin
      s_c[k] = SW'(rel_u[k]) + SW'(rel_v[k]) + SW'(rel_w[k]);
    end
  end

  // issue side: operand selection, tag, and sequencer next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sub_next   = sub;
    mul_a      = '0;
    mul_b      = '0;
    tag        = '0;
    stall      = 1'b0;
    ax_a       = AX_X;
    ax_b       = AX_X;
    pi         = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!s_axis_tuser && facet_cnt == 2'd2) begin
            state_next = ST_PREP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_PREP: begin
        state_next = ST_CROSS;
        cnt_next   = '0;
      end
      ST_CROSS: begin
        // c[k] = u[a] v[b] - u[b] v[a]
        ax_a = cross_axis_a(cnt[2:1]);
        ax_b = cross_axis_b(cnt[2:1]);
        if (!cnt[0]) begin
          mul_a = AW'(u_r[ax_a]);
          mul_b = BW'(v_r[ax_b]);
        end else begin
          mul_a = AW'(u_r[ax_b]);
          mul_b = -BW'(v_r[ax_a]);
        end
        tag.valid = 1'b1;
        tag.first = !cnt[0];
        tag.last  = cnt[0];
        tag.dst   = DST_CROSS;
        tag.idx   = {1'b0, cnt[2:1]};
        if (cnt == CROSS_OPS_LAST) begin
          state_next = ST_POLY;
          cnt_next   = '0;
          sub_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      ST_POLY: begin
        // P = sa*sb + ua*ub + va*vb + wa*wb + z0*extra
        pi   = cnt[2:0];
        ax_a = poly_axis_a(pi);
        ax_b = poly_axis_b(pi);
        case (sub)
          3'd0: begin
            mul_a = AW'(s_r[ax_a]);
            mul_b = BW'(s_r[ax_b]);
          end
          3'd1: begin
            mul_a = AW'(u_r[ax_a]);
            mul_b = BW'(u_r[ax_b]);
          end
          3'd2: begin
            mul_a = AW'(v_r[ax_a]);
            mul_b = BW'(v_r[ax_b]);
          end
          3'd3: begin
            mul_a = AW'(w_r[ax_a]);
            mul_b = BW'(w_r[ax_b]);
          end
          default: begin
            mul_a = AW'(reference_z);
            case (pi)
              3'd2:    mul_b = e_qz;
              3'd4:    mul_b = e_myz;
              3'd5:    mul_b = e_mxz;
              default: mul_b = '0;
            endcase
          end
        endcase
        tag.valid = 1'b1;
        tag.first = (sub == 3'd0);
        tag.last  = (sub == TERM_LAST);
        tag.dst   = DST_POLY;
        tag.idx   = pi;
        if (sub == TERM_LAST) begin
          sub_next = '0;
          if (cnt == POLY_LAST) begin
            state_next = ST_DET;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 5'd1;
          end
        end else begin
          sub_next = sub + 3'd1;
        end
      end
      ST_DET: begin
        mul_a     = AW'(cross_r[cnt[1:0]]);
        mul_b     = BW'(w_r[cnt[1:0]]);
        tag.valid = 1'b1;
        tag.first = (cnt == 5'd0);
        tag.last  = (cnt == DET_OPS_LAST);
        tag.dst   = DST_DET;
        if (cnt == DET_OPS_LAST) begin
          state_next = ST_BIG;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      ST_BIG: begin
        // wait for the determinant write-back before the first product
        stall = (cnt == 5'd0) && tag_q.valid;
        pi    = cnt[3:1];
        if (!stall) begin
          mul_a = det_r;
          if (cnt[0]) begin
            mul_b = BW'($signed(poly_r[pi][PW-1:LOW]));
          end else begin
            mul_b = BW'(poly_r[pi][LOW-1:0]);
          end
          tag.valid = 1'b1;
          tag.first = !cnt[0];
          tag.last  = cnt[0];
          tag.shift = cnt[0];
          tag.dst   = DST_BIG;
          tag.idx   = pi;
          if (cnt == BIG_OPS_LAST) begin
            state_next = ST_SUM;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 5'd1;
          end
        end
      end
      ST_SUM: begin
        stall = (cnt == 5'd0) && tag_q.valid;
        if (!stall) begin
          if (cnt == SUM_OPS_LAST) begin
            state_next = ST_DONE;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 5'd1;
          end
        end
      end
      ST_DONE: begin
        if (!last_q || emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // accumulate side
  always_comb begin
    if (tag_q.shift) begin
      addend = $signed({prod_q, {LOW{1'b0}}});
    end else begin
      addend = ACW'(prod_q);
    end
    acc_sum = (tag_q.first ? '0 : acc) + addend;
    sum_e   = EW'(acc_sum);
    if (sum_e > EW'(SMAX)) begin
      big_sat = SMAX;
    end else if (sum_e < EW'(SMIN)) begin
      big_sat = SMIN;
    end else begin
      big_sat = sum_e[SUM_BITS-1:0];
    end
  end

  // pair sums first, then the six running sums
  always_comb begin
    case (cnt)
      5'd0: begin sa = big_r[1];  sb = big_r[2];  end
      5'd1: begin sa = big_r[0];  sb = big_r[2];  end
      5'd2: begin sa = big_r[0];  sb = big_r[1];  end
      5'd3: begin sa = tensor[0]; sb = pair_r[0]; end
      5'd4: begin sa = tensor[1]; sb = pair_r[1]; end
      5'd5: begin sa = tensor[2]; sb = pair_r[2]; end
      5'd6: begin sa = tensor[3]; sb = big_r[3];  end
      5'd7: begin sa = tensor[4]; sb = big_r[4];  end
      default: begin sa = tensor[5]; sb = big_r[5]; end
    endcase
    s_wide = (SUM_BITS+1)'(sa) + (SUM_BITS+1)'(sb);
    if (s_wide[SUM_BITS] != s_wide[SUM_BITS-1]) begin
      sat_sum = s_wide[SUM_BITS] ? SMIN : SMAX;
    end else begin
      sat_sum = s_wide[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sub   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sub   <= sub_next;
    end
  end

  // control state and the running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      facet_cnt   <= '0;
      last_q      <= 1'b0;
      m_valid     <= 1'b0;
      tag_q       <= '0;
      reference_z <= '0;
      for (int k = 0; k < NUM_SUMS; k++) begin
        tensor[k] <= '0;
      end
    end else begin
      tag_q <= tag;
      if (cfg_wr_en) begin
        reference_z <= $signed(cfg_wr_data);
      end
      if (accept) begin
        last_q <= s_axis_tlast;
        if (s_axis_tuser || facet_cnt == 2'd0) begin
          facet_cnt <= 2'd1;
        end else if (facet_cnt == 2'd1) begin
          facet_cnt <= 2'd2;
        end
      end
      if (state == ST_SUM && !stall) begin
        case (cnt)
          5'd3:    tensor[0] <= sat_sum;
          5'd4:    tensor[1] <= sat_sum;
          5'd5:    tensor[2] <= sat_sum;
          5'd6:    tensor[3] <= sat_sum;
          5'd7:    tensor[4] <= sat_sum;
          5'd8:    tensor[5] <= sat_sum;
          default: ;
        endcase
      end
      if (emit) begin
        m_valid   <= 1'b1;
        facet_cnt <= '0;
        for (int k = 0; k < NUM_SUMS; k++) begin
          tensor[k] <= '0;
        end
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if (s_axis_tuser || facet_cnt == 2'd0) begin
        base_c <= in_c;
      end else if (facet_cnt == 2'd1) begin
        prev_c <= in_c;
      end else begin
        cur_c <= in_c;
      end
    end
    if (state == ST_PREP) begin
      u_r   <= rel_u;
      v_r   <= rel_v;
      w_r   <= rel_w;
      s_r   <= s_c;
      // 20 z0 + 10 sz, 5 sy, 5 sx
      e_qz  <= (BW'(reference_z) <<< 4) + (BW'(reference_z) <<< 2)
             + (BW'(s_c[2]) <<< 3) + (BW'(s_c[2]) <<< 1);
      e_myz <= (BW'(s_c[1]) <<< 2) + BW'(s_c[1]);
      e_mxz <= (BW'(s_c[0]) <<< 2) + BW'(s_c[0]);
    end
    prod_q <= mul_a * mul_b;
    if (tag_q.valid) begin
      acc <= acc_sum;
      if (tag_q.last) begin
        case (tag_q.dst)
          DST_CROSS: cross_r[tag_q.idx[1:0]] <= acc_sum[XW-1:0];
          DST_DET:   det_r                   <= acc_sum[DETW-1:0];
          DST_POLY:  poly_r[tag_q.idx]       <= acc_sum[PW-1:0];
          DST_BIG:   big_r[tag_q.idx]        <= big_sat;
          default:   ;
        endcase
      end
    end
    if (state == ST_SUM && !stall) begin
      case (cnt)
        5'd0:    pair_r[0] <= sat_sum;
        5'd1:    pair_r[1] <= sat_sum;
        5'd2:    pair_r[2] <= sat_sum;
        5'd8:    prev_c    <= cur_c;
        default: ;
      endcase
    end
    if (emit) begin
      out_r <= tensor;
    end
  end

endmodule

FILE: src/itacc_checker.sv
// itacc_checker: port-level assertions for inertia_tensor_accumulator, bound to the top level.
// Depends on itacc_pkg.
module itacc_checker #(
  parameter int COORD_BITS = itacc_pkg::COORD_BITS_DEF,
  parameter int SUM_BITS   = itacc_pkg::SUM_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((6*SUM_BITS+7)/8)*8-1:0]      m_axis_tdata
);
  import itacc_pkg::*;

  // a result held back keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // every vertex transfer is followed by input ready going low
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a transfer");

  // a new result only appears out of a busy state, never from idle
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while idle");

  // no result can be raised while the previous one is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result overrun");

endmodule

bind inertia_tensor_accumulator itacc_checker #(
  .COORD_BITS(COORD_BITS),
  .SUM_BITS  (SUM_BITS)
) u_itacc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
